>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define PCRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// cons must hold at the edge after ante
`define PCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pcrc_pkg.sv
// ----------------------------------------------------------------------------
// pcrc_pkg
// Types, widths and register codes of the region centroid block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcrc_pkg;

  localparam int COORD_W   = 8;
  localparam int SUM_W     = 24;
  localparam int CNT_W     = 17;
  localparam int NUM_VERTS = 4;
  localparam int CFG_IDX_W = 4;
  localparam int DIFF_W    = 10;
  localparam int PROD_W    = 20;

  localparam int RASTER_SIZE_DEF   = 240;
  localparam int CIRCLE_CENTER_DEF = 120;
  localparam int INNER_RADIUS_DEF  = 112;
  localparam int FIFO_DEPTH_DEF    = 4;

  typedef logic [COORD_W-1:0]       coord_t;
  typedef logic [SUM_W-1:0]         sum_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [PROD_W-1:0]        mag_t;

  localparam cfg_idx_t CFG_VERT0_X = 4'd0;
  localparam cfg_idx_t CFG_VERT0_Y = 4'd1;
  localparam cfg_idx_t CFG_VERT1_X = 4'd2;
  localparam cfg_idx_t CFG_VERT1_Y = 4'd3;
  localparam cfg_idx_t CFG_VERT2_X = 4'd4;
  localparam cfg_idx_t CFG_VERT2_Y = 4'd5;
  localparam cfg_idx_t CFG_VERT3_X = 4'd6;
  localparam cfg_idx_t CFG_VERT3_Y = 4'd7;

  localparam coord_t BOX_MIN_EMPTY = '0;

  // classified pixel, as queued between front and back
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   hit;
    logic   last;
  } pix_item_t;

endpackage

`default_nettype wire

>>> rtl/pcrc_div.sv
// ----------------------------------------------------------------------------
// pcrc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrc_div #(
  parameter int NUM_W = pcrc_pkg::SUM_W,
  parameter int DEN_W = pcrc_pkg::CNT_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int STEP_W = $clog2(NUM_W);
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t LAST_STEP = step_t'(NUM_W - 1);

  logic             run_r;
  step_t            step_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_step;

  assign trial    = {rem_r, num_r[NUM_W-1]};
  assign diff     = trial - {1'b0, den_r};
  assign ge       = trial >= {1'b0, den_r};
  assign rem_step = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  assign quot     = {num_r[NUM_W-2:0], ge};
  assign done     = run_r && (step_r == LAST_STEP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      step_r <= '0;
    end else if (done) begin
      run_r  <= 1'b0;
    end else if (run_r) begin
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (run_r) begin
      num_r <= quot;
      rem_r <= rem_step;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pcrc_front.sv
// ----------------------------------------------------------------------------
// pcrc_front
// Pixel intake: circle and crossing-number polygon test, products registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrc_front #(
  parameter int CIRCLE_CENTER = pcrc_pkg::CIRCLE_CENTER_DEF,
  parameter int INNER_RADIUS  = pcrc_pkg::INNER_RADIUS_DEF,
  parameter int FIFO_DEPTH    = pcrc_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire pcrc_pkg::coord_t              in_pix_x,
  input  wire pcrc_pkg::coord_t              in_pix_y,
  input  wire logic                          in_last_pixel,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire pcrc_pkg::cfg_idx_t            cfg_index,
  input  wire pcrc_pkg::coord_t              cfg_data,
  input  wire logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_level,
  output logic                               push,
  output pcrc_pkg::pix_item_t                push_item
);

  localparam int NV    = pcrc_pkg::NUM_VERTS;
  localparam int LVL_W = $clog2(FIFO_DEPTH + 1);
  typedef logic [LVL_W:0] room_t;
  localparam room_t          DEPTH_ROOM = room_t'(FIFO_DEPTH);
  localparam pcrc_pkg::diff_t CENTER    = pcrc_pkg::diff_t'(CIRCLE_CENTER);
  localparam pcrc_pkg::mag_t  R_SQ      = pcrc_pkg::mag_t'(INNER_RADIUS * INNER_RADIUS);

  pcrc_pkg::coord_t vx_r [NV];
  pcrc_pkg::coord_t vy_r [NV];

  logic             accept;
  pcrc_pkg::diff_t  dx_c;
  pcrc_pkg::diff_t  dy_c;
  pcrc_pkg::prod_t  sqx_c;
  pcrc_pkg::prod_t  sqy_c;
  logic [NV-1:0]    above_c;
  logic [NV-1:0]    cross_c;
  logic [NV-1:0]    denpos_c;
  pcrc_pkg::prod_t  lhs_c [NV];
  pcrc_pkg::prod_t  rhs_c [NV];

  logic             b_vld_r;
  pcrc_pkg::coord_t b_x_r;
  pcrc_pkg::coord_t b_y_r;
  logic             b_last_r;
  logic [pcrc_pkg::PROD_W-2:0] b_sqx_r;
  logic [pcrc_pkg::PROD_W-2:0] b_sqy_r;
  logic [NV-1:0]    b_cross_r;
  logic [NV-1:0]    b_denpos_r;
  pcrc_pkg::prod_t  b_lhs_r [NV];
  pcrc_pkg::prod_t  b_rhs_r [NV];

  logic [NV-1:0]    left_c;
  pcrc_pkg::mag_t   circ_sum;
  logic             hit_c;

  assign cfg_ready = 1'b1;
  assign busy      = ({1'b0, fifo_level} + room_t'(b_vld_r)) >= DEPTH_ROOM;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NV; k++) begin
        vx_r[k] <= '0;
        vy_r[k] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        pcrc_pkg::CFG_VERT0_X: vx_r[0] <= cfg_data;
        pcrc_pkg::CFG_VERT0_Y: vy_r[0] <= cfg_data;
        pcrc_pkg::CFG_VERT1_X: vx_r[1] <= cfg_data;
        pcrc_pkg::CFG_VERT1_Y: vy_r[1] <= cfg_data;
        pcrc_pkg::CFG_VERT2_X: vx_r[2] <= cfg_data;
        pcrc_pkg::CFG_VERT2_Y: vy_r[2] <= cfg_data;
        pcrc_pkg::CFG_VERT3_X: vx_r[3] <= cfg_data;
        pcrc_pkg::CFG_VERT3_Y: vy_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage one: differences and products
  assign dx_c  = pcrc_pkg::diff_t'({2'b00, in_pix_x}) - CENTER;
  assign dy_c  = pcrc_pkg::diff_t'({2'b00, in_pix_y}) - CENTER;
  assign sqx_c = pcrc_pkg::prod_t'(dx_c) * pcrc_pkg::prod_t'(dx_c);
  assign sqy_c = pcrc_pkg::prod_t'(dy_c) * pcrc_pkg::prod_t'(dy_c);

  for (genvar i = 0; i < NV; i++) begin : g_edge
    localparam int J = (i == 0) ? NV - 1 : i - 1;
    pcrc_pkg::diff_t den;
    pcrc_pkg::diff_t rel_x;
    pcrc_pkg::diff_t rel_y;
    pcrc_pkg::diff_t run_x;
    assign above_c[i]  = vy_r[i] > in_pix_y;
    assign cross_c[i]  = above_c[i] != above_c[J];
    assign den         = pcrc_pkg::diff_t'({2'b00, vy_r[J]}) -
                         pcrc_pkg::diff_t'({2'b00, vy_r[i]});
    assign rel_x       = pcrc_pkg::diff_t'({2'b00, in_pix_x}) -
                         pcrc_pkg::diff_t'({2'b00, vx_r[i]});
    assign rel_y       = pcrc_pkg::diff_t'({2'b00, in_pix_y}) -
                         pcrc_pkg::diff_t'({2'b00, vy_r[i]});
    assign run_x       = pcrc_pkg::diff_t'({2'b00, vx_r[J]}) -
                         pcrc_pkg::diff_t'({2'b00, vx_r[i]});
    assign denpos_c[i] = den > 0;
    assign lhs_c[i]    = pcrc_pkg::prod_t'(rel_x) * pcrc_pkg::prod_t'(den);
    assign rhs_c[i]    = pcrc_pkg::prod_t'(run_x) * pcrc_pkg::prod_t'(rel_y);
    assign left_c[i]   = b_denpos_r[i] ? (b_lhs_r[i] < b_rhs_r[i])
                                       : (b_lhs_r[i] > b_rhs_r[i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_x_r      <= in_pix_x;
      b_y_r      <= in_pix_y;
      b_last_r   <= in_last_pixel;
      b_sqx_r    <= sqx_c[pcrc_pkg::PROD_W-2:0];
      b_sqy_r    <= sqy_c[pcrc_pkg::PROD_W-2:0];
      b_cross_r  <= cross_c;
      b_denpos_r <= denpos_c;
      for (int k = 0; k < NV; k++) begin
        b_lhs_r[k] <= lhs_c[k];
        b_rhs_r[k] <= rhs_c[k];
      end
    end
  end

  // stage two: compares, odd crossing count means inside
  assign circ_sum = {1'b0, b_sqx_r} + {1'b0, b_sqy_r};
  assign hit_c    = (circ_sum <= R_SQ) && (^(b_cross_r & left_c));

  assign push           = b_vld_r && (hit_c || b_last_r);
  assign push_item.x    = b_x_r;
  assign push_item.y    = b_y_r;
  assign push_item.hit  = hit_c;
  assign push_item.last = b_last_r;

endmodule

`default_nettype wire

>>> rtl/pcrc_fifo.sv
// ----------------------------------------------------------------------------
// pcrc_fifo
// Short queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pcrc_fifo #(
  parameter int DEPTH = pcrc_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire pcrc_pkg::pix_item_t        push_item,
  input  wire logic                       pop,
  output pcrc_pkg::pix_item_t             head_item,
  output logic                            not_empty,
  output logic [$clog2(DEPTH+1)-1:0]      level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [LVL_W-1:0] lvl_t;
  localparam ptr_t LAST_PTR = ptr_t'(DEPTH - 1);
  localparam lvl_t FULL_LVL = lvl_t'(DEPTH);

  pcrc_pkg::pix_item_t mem_r [DEPTH];
  ptr_t wr_ptr_r;
  ptr_t rd_ptr_r;
  lvl_t level_r;

  assign head_item = mem_r[rd_ptr_r];
  assign not_empty = level_r != '0;
  assign level     = level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   level_r <= level_r + 1'b1;
        2'b01:   level_r <= level_r - 1'b1;
        default: level_r <= level_r;
      endcase
    end
  end

  `PCRC_ASSERT(a_no_overflow, (level_r == FULL_LVL) |-> !push, "push into full queue")
  `PCRC_ASSERT(a_no_underflow, (level_r == '0) |-> !pop, "pop from empty queue")

endmodule

`default_nettype wire

>>> rtl/pcrc_back.sv
// ----------------------------------------------------------------------------
// pcrc_back
// Accumulates sums, count, box; on the last pixel divides if any hit, reports.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pcrc_back #(
  parameter int RASTER_SIZE   = pcrc_pkg::RASTER_SIZE_DEF,
  parameter int CIRCLE_CENTER = pcrc_pkg::CIRCLE_CENTER_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_not_empty,
  input  wire pcrc_pkg::pix_item_t q_item,
  output logic                     q_pop,
  output logic                     out_strobe,
  output pcrc_pkg::coord_t         out_cent_x,
  output pcrc_pkg::coord_t         out_cent_y,
  output pcrc_pkg::coord_t         out_box_min_x,
  output pcrc_pkg::coord_t         out_box_min_y,
  output pcrc_pkg::coord_t         out_box_max_x,
  output pcrc_pkg::coord_t         out_box_max_y,
  output logic                     out_region_empty
);

  localparam logic ST_RUN = 1'b0;
  localparam logic ST_DIV = 1'b1;
  localparam pcrc_pkg::coord_t DEF_CENT = pcrc_pkg::coord_t'(CIRCLE_CENTER);
  localparam pcrc_pkg::coord_t DEF_MAX  = pcrc_pkg::coord_t'(RASTER_SIZE - 1);

  function automatic pcrc_pkg::coord_t sat8(pcrc_pkg::sum_t q);
    return (|q[pcrc_pkg::SUM_W-1:pcrc_pkg::COORD_W]) ? '1 : q[pcrc_pkg::COORD_W-1:0];
  endfunction

  logic             state_r;
  logic             out_strobe_r;
  pcrc_pkg::sum_t   sum_col_r, sum_col_nxt;
  pcrc_pkg::sum_t   sum_row_r, sum_row_nxt;
  pcrc_pkg::cnt_t   cnt_r, cnt_nxt;
  pcrc_pkg::coord_t low_col_r, low_col_nxt;
  pcrc_pkg::coord_t low_row_r, low_row_nxt;
  pcrc_pkg::coord_t high_col_r, high_col_nxt;
  pcrc_pkg::coord_t high_row_r, high_row_nxt;

  pcrc_pkg::coord_t cent_x_r, cent_y_r;
  pcrc_pkg::coord_t min_x_r, min_y_r, max_x_r, max_y_r;
  logic             empty_r;

  logic             hit;
  logic             fin;
  logic             fin_empty;
  logic             div_start;
  logic             div_x_done;
  logic             div_y_done;
  pcrc_pkg::sum_t   quot_x;
  pcrc_pkg::sum_t   quot_y;

  assign q_pop     = q_not_empty && (state_r == ST_RUN);
  assign hit       = q_pop && q_item.hit;
  assign fin       = q_pop && q_item.last;
  assign fin_empty = cnt_nxt == '0;
  assign div_start = fin && !fin_empty;

  always_comb begin
    sum_col_nxt  = sum_col_r;
    sum_row_nxt  = sum_row_r;
    cnt_nxt      = cnt_r;
    low_col_nxt  = low_col_r;
    low_row_nxt  = low_row_r;
    high_col_nxt = high_col_r;
    high_row_nxt = high_row_r;
    if (hit) begin
      sum_col_nxt = sum_col_r + pcrc_pkg::sum_t'(q_item.x);
      sum_row_nxt = sum_row_r + pcrc_pkg::sum_t'(q_item.y);
      cnt_nxt     = cnt_r + 1'b1;
      if (cnt_r == '0) begin
        low_col_nxt  = q_item.x;
        high_col_nxt = q_item.x;
        low_row_nxt  = q_item.y;
        high_row_nxt = q_item.y;
      end else begin
        if (q_item.x < low_col_r)  low_col_nxt  = q_item.x;
        if (q_item.x > high_col_r) high_col_nxt = q_item.x;
        if (q_item.y < low_row_r)  low_row_nxt  = q_item.y;
        if (q_item.y > high_row_r) high_row_nxt = q_item.y;
      end
    end
  end

  pcrc_div #(
    .NUM_W(pcrc_pkg::SUM_W),
    .DEN_W(pcrc_pkg::CNT_W)
  ) u_div_x (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (sum_col_nxt),
    .den  (cnt_nxt),
    .done (div_x_done),
    .quot (quot_x)
  );

  pcrc_div #(
    .NUM_W(pcrc_pkg::SUM_W),
    .DEN_W(pcrc_pkg::CNT_W)
  ) u_div_y (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (sum_row_nxt),
    .den  (cnt_nxt),
    .done (div_y_done),
    .quot (quot_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      out_strobe_r <= 1'b0;
      sum_col_r    <= '0;
      sum_row_r    <= '0;
      cnt_r        <= '0;
      low_col_r    <= '0;
      low_row_r    <= '0;
      high_col_r   <= '0;
      high_row_r   <= '0;
    end else begin
      case (state_r)
        ST_RUN: begin
          out_strobe_r <= fin && fin_empty;
          if (fin) begin
            sum_col_r  <= '0;
            sum_row_r  <= '0;
            cnt_r      <= '0;
            low_col_r  <= '0;
            low_row_r  <= '0;
            high_col_r <= '0;
            high_row_r <= '0;
            if (!fin_empty) begin
              state_r <= ST_DIV;
            end
          end else begin
            sum_col_r  <= sum_col_nxt;
            sum_row_r  <= sum_row_nxt;
            cnt_r      <= cnt_nxt;
            low_col_r  <= low_col_nxt;
            low_row_r  <= low_row_nxt;
            high_col_r <= high_col_nxt;
            high_row_r <= high_row_nxt;
          end
        end
        ST_DIV: begin
          out_strobe_r <= div_x_done;
          if (div_x_done) begin
            state_r <= ST_RUN;
          end
        end
        default: begin
          out_strobe_r <= 1'b0;
          state_r      <= ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      empty_r <= fin_empty;
      if (fin_empty) begin
        cent_x_r <= DEF_CENT;
        cent_y_r <= DEF_CENT;
        min_x_r  <= pcrc_pkg::BOX_MIN_EMPTY;
        min_y_r  <= pcrc_pkg::BOX_MIN_EMPTY;
        max_x_r  <= DEF_MAX;
        max_y_r  <= DEF_MAX;
      end else begin
        min_x_r  <= low_col_nxt;
        min_y_r  <= low_row_nxt;
        max_x_r  <= high_col_nxt;
        max_y_r  <= high_row_nxt;
      end
    end
    if (div_x_done) begin
      cent_x_r <= sat8(quot_x);
      cent_y_r <= sat8(quot_y);
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_cent_x       = cent_x_r;
  assign out_cent_y       = cent_y_r;
  assign out_box_min_x    = min_x_r;
  assign out_box_min_y    = min_y_r;
  assign out_box_max_x    = max_x_r;
  assign out_box_max_y    = max_y_r;
  assign out_region_empty = empty_r;

  `PCRC_ASSERT(a_div_lockstep, div_x_done == div_y_done, "x and y dividers out of step")
  `PCRC_ASSERT(a_done_in_div, div_x_done |-> (state_r == ST_DIV), "divide ends outside DIV")
  `PCRC_ASSERT_NEXT(a_done_strobe, div_x_done, out_strobe_r && (state_r == ST_RUN),
    "divide end not reported")

endmodule

`default_nettype wire

>>> rtl/polygon_circle_region_centroid.sv
// ----------------------------------------------------------------------------
// polygon_circle_region_centroid
// Centroid and bounding box of raster pixels inside a circle and a polygon.
// ----------------------------------------------------------------------------
// Input beats: pix_x, pix_y, last_pixel, taken on an edge with start high and
// busy low. A steady scan is taken at one pixel per cycle; busy rises only
// while the frame-end divide runs and the queue in front of it has filled.
// Config: four polygon vertices over the cfg_ write channel (cfg_ready is
// always high); the user must write them while the block is idle, which the block itself does not enforce.
// Each pixel passes a registered classify pipeline; pixels that count, and
// the last pixel, go through a short queue to the accumulator.
// Result beat: out_strobe high for one cycle per last pixel. With no pixel
// counted the result is registered from the popped last pixel; otherwise
// two 24-step bit-serial dividers set it. While they run, the queue takes
// up to FIFO_DEPTH more counted or last pixels before busy holds off the next.
// The receiver cannot stall; every result beat is final when shown.
// Reset clears vertices, sums, count and box; no result is pending after it.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_circle_region_centroid #(
  parameter int RASTER_SIZE   = pcrc_pkg::RASTER_SIZE_DEF,
  parameter int CIRCLE_CENTER = pcrc_pkg::CIRCLE_CENTER_DEF,
  parameter int INNER_RADIUS  = pcrc_pkg::INNER_RADIUS_DEF,
  parameter int FIFO_DEPTH    = pcrc_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire pcrc_pkg::coord_t   in_pix_x,
  input  wire pcrc_pkg::coord_t   in_pix_y,
  input  wire logic               in_last_pixel,
  output logic                    out_strobe,
  output pcrc_pkg::coord_t        out_cent_x,
  output pcrc_pkg::coord_t        out_cent_y,
  output pcrc_pkg::coord_t        out_box_min_x,
  output pcrc_pkg::coord_t        out_box_min_y,
  output pcrc_pkg::coord_t        out_box_max_x,
  output pcrc_pkg::coord_t        out_box_max_y,
  output logic                    out_region_empty,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire pcrc_pkg::cfg_idx_t cfg_index,
  input  wire pcrc_pkg::coord_t   cfg_data
);

  localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

  logic                push;
  pcrc_pkg::pix_item_t push_item;
  logic                pop;
  pcrc_pkg::pix_item_t head_item;
  logic                not_empty;
  logic [LVL_W-1:0]    level;

  pcrc_front #(
    .CIRCLE_CENTER(CIRCLE_CENTER),
    .INNER_RADIUS (INNER_RADIUS),
    .FIFO_DEPTH   (FIFO_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_pix_x     (in_pix_x),
    .in_pix_y     (in_pix_y),
    .in_last_pixel(in_last_pixel),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fifo_level   (level),
    .push         (push),
    .push_item    (push_item)
  );

  pcrc_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head_item(head_item),
    .not_empty(not_empty),
    .level    (level)
  );

  pcrc_back #(
    .RASTER_SIZE  (RASTER_SIZE),
    .CIRCLE_CENTER(CIRCLE_CENTER)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (not_empty),
    .q_item          (head_item),
    .q_pop           (pop),
    .out_strobe      (out_strobe),
    .out_cent_x      (out_cent_x),
    .out_cent_y      (out_cent_y),
    .out_box_min_x   (out_box_min_x),
    .out_box_min_y   (out_box_min_y),
    .out_box_max_x   (out_box_max_x),
    .out_box_max_y   (out_box_max_y),
    .out_region_empty(out_region_empty)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for polygon_circle_region_centroid. Pixel beats are
// driven over start/busy in short frames, mostly aimed at the programmed
// polygon, under a series of vertex settings from degenerate to random.
// A scoreboard classifies every accepted pixel with its own circle and
// crossing-number test, accumulates sums and box, and checks each out_strobe
// beat against the oldest predicted region.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    pcrc_pkg::coord_t cent_x;
    pcrc_pkg::coord_t cent_y;
    pcrc_pkg::coord_t min_x;
    pcrc_pkg::coord_t min_y;
    pcrc_pkg::coord_t max_x;
    pcrc_pkg::coord_t max_y;
    logic             empty;
  } region_t;

  class region_scoreboard;
    pcrc_pkg::coord_t vx[pcrc_pkg::NUM_VERTS];
    pcrc_pkg::coord_t vy[pcrc_pkg::NUM_VERTS];
    pcrc_pkg::sum_t   sum_col;
    pcrc_pkg::sum_t   sum_row;
    pcrc_pkg::cnt_t   hit_count;
    pcrc_pkg::coord_t low_col, low_row, high_col, high_row;
    region_t          want_q[$];
    int               errors, frames, empties, hits, pixels;

    function new();
      foreach (vx[i]) begin
        vx[i] = '0;
        vy[i] = '0;
      end
      clear_frame();
      errors  = 0;
      frames  = 0;
      empties = 0;
      hits    = 0;
      pixels  = 0;
    endfunction

    function void clear_frame();
      sum_col   = '0;
      sum_row   = '0;
      hit_count = '0;
      low_col   = '0;
      low_row   = '0;
      high_col  = '0;
      high_row  = '0;
    endfunction

    function void write_reg(pcrc_pkg::cfg_idx_t idx, pcrc_pkg::coord_t val);
      case (idx)
        pcrc_pkg::CFG_VERT0_X: vx[0] = val;
        pcrc_pkg::CFG_VERT0_Y: vy[0] = val;
        pcrc_pkg::CFG_VERT1_X: vx[1] = val;
        pcrc_pkg::CFG_VERT1_Y: vy[1] = val;
        pcrc_pkg::CFG_VERT2_X: vx[2] = val;
        pcrc_pkg::CFG_VERT2_Y: vy[2] = val;
        pcrc_pkg::CFG_VERT3_X: vx[3] = val;
        pcrc_pkg::CFG_VERT3_Y: vy[3] = val;
        default: ;
      endcase
    endfunction

    function bit in_circle(pcrc_pkg::coord_t x, pcrc_pkg::coord_t y);
      int dx, dy;
      dx = int'(x) - pcrc_pkg::CIRCLE_CENTER_DEF;
      dy = int'(y) - pcrc_pkg::CIRCLE_CENTER_DEF;
      return (dx * dx + dy * dy) <= pcrc_pkg::INNER_RADIUS_DEF * pcrc_pkg::INNER_RADIUS_DEF;
    endfunction

    function bit in_polygon(pcrc_pkg::coord_t x, pcrc_pkg::coord_t y);
      int px, py, xi, yi, xj, yj, den, lhs, rhs, j;
      bit odd_cross, left;
      px = x;
      py = y;
      odd_cross = 1'b0;
      j = pcrc_pkg::NUM_VERTS - 1;
      for (int i = 0; i < pcrc_pkg::NUM_VERTS; i++) begin
        xi = vx[i];
        yi = vy[i];
        xj = vx[j];
        yj = vy[j];
        // horizontal edges never pass this test
        if ((yi > py) != (yj > py)) begin
          den  = yj - yi;
          lhs  = (px - xi) * den;
          rhs  = (xj - xi) * (py - yi);
          left = (den > 0) ? (lhs < rhs) : (lhs > rhs);
          if (left) odd_cross = !odd_cross;
        end
        j = i;
      end
      return odd_cross;
    endfunction

    function pcrc_pkg::coord_t floor_mean(pcrc_pkg::sum_t s, pcrc_pkg::cnt_t n);
      pcrc_pkg::sum_t m;
      m = s / pcrc_pkg::sum_t'(n);
      return (m > pcrc_pkg::sum_t'({pcrc_pkg::COORD_W{1'b1}})) ? {pcrc_pkg::COORD_W{1'b1}}
                                                             : m[pcrc_pkg::COORD_W-1:0];
    endfunction

    function void note_pixel(pcrc_pkg::coord_t x, pcrc_pkg::coord_t y, logic last);
      region_t r;
      pixels++;
      if (in_circle(x, y) && in_polygon(x, y)) begin
        if (hit_count == 0) begin
          low_col  = x;
          high_col = x;
          low_row  = y;
          high_row = y;
        end else begin
          if (x < low_col)  low_col  = x;
          if (x > high_col) high_col = x;
          if (y < low_row)  low_row  = y;
          if (y > high_row) high_row = y;
        end
        sum_col   = sum_col + pcrc_pkg::sum_t'(x);
        sum_row   = sum_row + pcrc_pkg::sum_t'(y);
        hit_count = hit_count + 1'b1;
        hits++;
      end
      if (last) begin
        if (hit_count == 0) begin
          r.cent_x = pcrc_pkg::coord_t'(pcrc_pkg::CIRCLE_CENTER_DEF);
          r.cent_y = pcrc_pkg::coord_t'(pcrc_pkg::CIRCLE_CENTER_DEF);
          r.min_x  = pcrc_pkg::BOX_MIN_EMPTY;
          r.min_y  = pcrc_pkg::BOX_MIN_EMPTY;
          r.max_x  = pcrc_pkg::coord_t'(pcrc_pkg::RASTER_SIZE_DEF - 1);
          r.max_y  = pcrc_pkg::coord_t'(pcrc_pkg::RASTER_SIZE_DEF - 1);
          r.empty  = 1'b1;
          empties++;
        end else begin
          r.cent_x = floor_mean(sum_col, hit_count);
          r.cent_y = floor_mean(sum_row, hit_count);
          r.min_x  = low_col;
          r.min_y  = low_row;
          r.max_x  = high_col;
          r.max_y  = high_row;
          r.empty  = 1'b0;
        end
        want_q.push_back(r);
        frames++;
        clear_frame();
      end
    endfunction

    function string show(region_t r);
      return $sformatf("cent=(%0d,%0d) box=(%0d,%0d)-(%0d,%0d) empty=%0b",
                       r.cent_x, r.cent_y, r.min_x, r.min_y, r.max_x, r.max_y, r.empty);
    endfunction

    function void check_result(region_t got);
      region_t want;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: result beat with none pending: %s", show(got));
        return;
      end
      want = want_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("tb: region mismatch at %0t", $realtime);
          $display("tb:   want %s", show(want));
          $display("tb:   got  %s", show(got));
        end
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               start         = 1'b0;
  logic               busy;
  pcrc_pkg::coord_t   in_pix_x      = '0;
  pcrc_pkg::coord_t   in_pix_y      = '0;
  logic               in_last_pixel = 1'b0;
  logic               out_strobe;
  pcrc_pkg::coord_t   out_cent_x, out_cent_y;
  pcrc_pkg::coord_t   out_box_min_x, out_box_min_y, out_box_max_x, out_box_max_y;
  logic               out_region_empty;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  pcrc_pkg::cfg_idx_t cfg_index     = '0;
  pcrc_pkg::coord_t   cfg_data      = '0;

  region_scoreboard sb;
  bit               idle_on = 1'b1;
  int               settings = 0;
  pcrc_pkg::coord_t box_lo_x, box_hi_x, box_lo_y, box_hi_y;

  polygon_circle_region_centroid dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_pix_x         (in_pix_x),
    .in_pix_y         (in_pix_y),
    .in_last_pixel    (in_last_pixel),
    .out_strobe       (out_strobe),
    .out_cent_x       (out_cent_x),
    .out_cent_y       (out_cent_y),
    .out_box_min_x    (out_box_min_x),
    .out_box_min_y    (out_box_min_y),
    .out_box_max_x    (out_box_max_x),
    .out_box_max_y    (out_box_max_y),
    .out_region_empty (out_region_empty),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_pixel(in_pix_x, in_pix_y, in_last_pixel);
      if (out_strobe) begin
        sb.check_result({out_cent_x, out_cent_y, out_box_min_x, out_box_min_y,
                         out_box_max_x, out_box_max_y, out_region_empty});
      end
    end
  end

  task automatic send_pixel(pcrc_pkg::coord_t x, pcrc_pkg::coord_t y, logic last);
    while (idle_on && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_pix_x      <= x;
    in_pix_y      <= y;
    in_last_pixel <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(pcrc_pkg::cfg_idx_t idx, pcrc_pkg::coord_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_polygon(pcrc_pkg::coord_t x0, pcrc_pkg::coord_t y0,
                                 pcrc_pkg::coord_t x1, pcrc_pkg::coord_t y1,
                                 pcrc_pkg::coord_t x2, pcrc_pkg::coord_t y2,
                                 pcrc_pkg::coord_t x3, pcrc_pkg::coord_t y3);
    pcrc_pkg::coord_t   xs[pcrc_pkg::NUM_VERTS];
    pcrc_pkg::coord_t   ys[pcrc_pkg::NUM_VERTS];
    pcrc_pkg::cfg_idx_t xi[pcrc_pkg::NUM_VERTS];
    pcrc_pkg::cfg_idx_t yi[pcrc_pkg::NUM_VERTS];
    xs = '{x0, x1, x2, x3};
    ys = '{y0, y1, y2, y3};
    xi = '{pcrc_pkg::CFG_VERT0_X, pcrc_pkg::CFG_VERT1_X,
           pcrc_pkg::CFG_VERT2_X, pcrc_pkg::CFG_VERT3_X};
    yi = '{pcrc_pkg::CFG_VERT0_Y, pcrc_pkg::CFG_VERT1_Y,
           pcrc_pkg::CFG_VERT2_Y, pcrc_pkg::CFG_VERT3_Y};
    box_lo_x = x0;
    box_hi_x = x0;
    box_lo_y = y0;
    box_hi_y = y0;
    for (int v = 0; v < pcrc_pkg::NUM_VERTS; v++) begin
      if (xs[v] < box_lo_x) box_lo_x = xs[v];
      if (xs[v] > box_hi_x) box_hi_x = xs[v];
      if (ys[v] < box_lo_y) box_lo_y = ys[v];
      if (ys[v] > box_hi_y) box_hi_y = ys[v];
      write_reg(xi[v], xs[v]);
      write_reg(yi[v], ys[v]);
    end
    // index past the vertex bank, must have no effect
    write_reg(pcrc_pkg::cfg_idx_t'($urandom_range(int'(pcrc_pkg::CFG_VERT3_Y) + 1,
                                                  (1 << pcrc_pkg::CFG_IDX_W) - 1)),
              pcrc_pkg::coord_t'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  task automatic random_polygon();
    pcrc_pkg::coord_t c[2*pcrc_pkg::NUM_VERTS];
    bit               tight;
    tight = ($urandom_range(0, 9) < 4);
    foreach (c[i]) c[i] = tight ? pcrc_pkg::coord_t'($urandom_range(40, 200))
                                : pcrc_pkg::coord_t'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 3) c[3] = c[1];
    program_polygon(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endtask

  task automatic send_frame(int len, bit noisy);
    pcrc_pkg::coord_t x, y;
    int               r;
    for (int k = 0; k < len; k++) begin
      r = noisy ? 99 : $urandom_range(0, 99);
      if (r < 60) begin
        x = pcrc_pkg::coord_t'($urandom_range(box_lo_x, box_hi_x));
        y = pcrc_pkg::coord_t'($urandom_range(box_lo_y, box_hi_y));
      end else if (r < 85) begin
        x = pcrc_pkg::coord_t'($urandom_range(
              pcrc_pkg::CIRCLE_CENTER_DEF - pcrc_pkg::INNER_RADIUS_DEF,
              pcrc_pkg::CIRCLE_CENTER_DEF + pcrc_pkg::INNER_RADIUS_DEF));
        y = pcrc_pkg::coord_t'($urandom_range(
              pcrc_pkg::CIRCLE_CENTER_DEF - pcrc_pkg::INNER_RADIUS_DEF,
              pcrc_pkg::CIRCLE_CENTER_DEF + pcrc_pkg::INNER_RADIUS_DEF));
      end else begin
        x = pcrc_pkg::coord_t'($urandom_range(0, 255));
        y = pcrc_pkg::coord_t'($urandom_range(0, 255));
      end
      send_pixel(x, y, k == len - 1);
    end
  endtask

  task automatic wait_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_results();
    repeat (64) @(posedge clk);
  endtask

  initial begin
    int len, budget, leftover;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // square with horizontal top and bottom edges
    program_polygon(40, 40, 200, 40, 200, 200, 40, 200);
    send_pixel(0, 0, 1'b1);
    send_pixel(120, 120, 1'b0);
    send_pixel(40, 100, 1'b0);
    send_pixel(200, 100, 1'b0);
    send_pixel(100, 40, 1'b0);
    send_pixel(100, 200, 1'b0);
    send_pixel(120, 8, 1'b0);
    send_pixel(255, 255, 1'b0);
    send_pixel(0, 255, 1'b0);
    send_pixel(255, 0, 1'b0);
    send_pixel(245, 120, 1'b0);
    send_pixel(60, 60, 1'b1);
    send_pixel(120, 120, 1'b1);
    send_pixel(255, 255, 1'b1);
    drain();

    // full-raster polygon, circle rim decides
    program_polygon(0, 0, 255, 0, 255, 255, 0, 255);
    send_pixel(120, 8, 1'b0);
    send_pixel(8, 120, 1'b0);
    send_pixel(232, 120, 1'b0);
    send_pixel(121, 8, 1'b0);
    send_pixel(120, 232, 1'b1);
    send_pixel(241, 241, 1'b1);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: program_polygon(0, 0, 0, 0, 0, 0, 0, 0);
        1: program_polygon(255, 255, 255, 255, 255, 255, 255, 255);
        2: program_polygon(8, 120, 120, 8, 232, 120, 120, 232);
        3: program_polygon(0, 0, 255, 0, 255, 255, 0, 255);
        default: random_polygon();
      endcase
      idle_on = (ph != 5);
      budget = 173;
      while (budget > 0) begin
        if ($urandom_range(0, 99) < 5) wait_results();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        if (len > budget) len = budget;
        send_frame(len, $urandom_range(0, 9) == 0);
        budget -= len;
      end
      drain();
    end

    start <= 1'b0;
    for (int w = 0; w < 4000 && sb.pending() != 0; w++) @(posedge clk);
    repeat (64) @(posedge clk);
    leftover = sb.pending();
    if (leftover != 0) begin
      sb.errors += leftover;
      $display("tb: %0d region results never arrived", leftover);
    end

    $display("tb: %0d pixels over %0d frames (%0d empty), %0d counted, %0d vertex settings",
             sb.pixels, sb.frames, sb.empties, sb.hits, settings);
    $display("tb: %0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: timeout");
    $display("tb: failure");
    $finish;
  end

endmodule
